@@ hw/rtl/ecb_pkg.sv @@
package ecb_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [17:0] YAW_FULL = 18'sd92160;
    localparam logic signed [17:0] YAW_RESET = -18'sd23040;
    localparam logic signed [15:0] PITCH_LIMIT = 16'sd22784;
    localparam logic [15:0] SENS_RESET = 16'd6554;
    localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [25:0] DEG_FULL = 26'sd23592960;
    localparam logic signed [25:0] DEG_HALF = 26'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [25:0] atan_lookup(input logic [4:0] i);
        logic signed [25:0] r;
        case (i)
            5'd0: r = 26'sd2949120;
            5'd1: r = 26'sd1740967;
            5'd2: r = 26'sd919879;
            5'd3: r = 26'sd466945;
            5'd4: r = 26'sd234379;
            5'd5: r = 26'sd117304;
            5'd6: r = 26'sd58666;
            5'd7: r = 26'sd29335;
            5'd8: r = 26'sd14668;
            5'd9: r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;
            5'd19: r = 26'sd7;
            5'd20: r = 26'sd4;
            5'd21: r = 26'sd2;
            5'd22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_STEP  = 8'b0000_0010,
        ST_WRAP  = 8'b0000_0100,
        ST_YAW   = 8'b0000_1000,
        ST_PITCH = 8'b0001_0000,
        ST_MULA  = 8'b0010_0000,
        ST_MULB  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } ecb_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture deltas, compute steps
        logic wrap;      // update angles
        logic trig_start;
        logic trig_sel;  // 0 yaw, 1 pitch
        logic store_yaw;
        logic store_pitch;
        logic mul_a;
        logic mul_b;
    } ecb_cmd_t;

    typedef struct packed {
        logic trig_done;
    } ecb_status_t;

endpackage

@@ hw/rtl/ecb_cordic.sv @@
module ecb_cordic import ecb_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [17:0]  angle,
    output logic                done,
    output logic signed [15:0]  sin_q14,
    output logic signed [15:0]  cos_q14
);
    localparam int ITER = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

    logic signed [32:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic               neg_reg, busy_reg, done_reg;
    logic [4:0]         i_reg;
    logic signed [25:0] z0, z1, z2;
    logic               neg0;

    // range reduction of the start angle
    always_comb begin
        z0 = 26'(angle * 26'sd256);
        z1 = z0;
        if (z1 >= DEG_HALF) z1 = z1 - DEG_FULL;
        if (z1 < -DEG_HALF) z1 = z1 + DEG_FULL;
        neg0 = 1'b0;
        z2 = z1;
        if (z1 > DEG_QUARTER) begin
            z2 = z1 - DEG_HALF;
            neg0 = 1'b1;
        end else if (z1 < -DEG_QUARTER) begin
            z2 = z1 + DEG_HALF;
            neg0 = 1'b1;
        end
    end

    // one rotation per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg <= '0;
                x_reg <= CORDIC_GAIN;
                y_reg <= '0;
                z_reg <= z2;
                neg_reg <= neg0;
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - (y_reg >>> i_reg);
                    y_reg <= y_reg + (x_reg >>> i_reg);
                    z_reg <= z_reg - atan_lookup(i_reg);
                end else begin
                    x_reg <= x_reg + (y_reg >>> i_reg);
                    y_reg <= y_reg - (x_reg >>> i_reg);
                    z_reg <= z_reg + atan_lookup(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // sign fix, truncating scale to q1.14 and clamp
    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v, input logic n);
        logic signed [33:0] s;
        logic signed [33:0] q;
        s = n ? -34'(v) : 34'(v);
        q = (s < 0) ? -((-s) >>> 16) : (s >>> 16);
        if (q > 34'sd16384) q = 34'sd16384;
        if (q < -34'sd16384) q = -34'sd16384;
        return q[15:0];
    endfunction

    assign done    = done_reg;
    assign sin_q14 = to_q14(y_reg, neg_reg);
    assign cos_q14 = to_q14(x_reg, neg_reg);
endmodule

@@ hw/rtl/ecb_datapath.sv @@
module ecb_datapath import ecb_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ecb_cmd_t           cmd,
    output ecb_status_t        status,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic signed [15:0] s_delta_x,
    input  logic signed [15:0] s_delta_y,
    output logic signed [15:0] front_x, front_y, front_z, right_x, right_z,
    output logic signed [15:0] up_x, up_y, up_z,
    output logic signed [17:0] yaw_out,
    output logic signed [15:0] pitch_out
);
    localparam logic signed [20:0] TURN_1 = 21'(YAW_FULL);
    localparam logic signed [20:0] TURN_2 = 21'(YAW_FULL) * 21'sd2;
    localparam logic signed [20:0] TURN_4 = 21'(YAW_FULL) * 21'sd4;

    logic [15:0]        sens_reg;
    logic signed [17:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    logic signed [19:0] dyaw_reg, dpitch_reg;
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [15:0] fx_reg, fz_reg, ux_reg, uz_reg;
    logic signed [15:0] tsin, tcos;
    logic               tdone;

    // sensitivity register
    always_ff @(posedge aclk) begin
        if (!aresetn) sens_reg <= SENS_RESET;
        else if (cfg_we) sens_reg <= cfg_wdata;
    end

    // truncating step: delta * sens / 4096
    function automatic logic signed [19:0] step(input logic signed [15:0] d,
                                                input logic [15:0] s);
        logic signed [32:0] p;
        logic signed [32:0] q;
        p = 33'(d) * $signed({1'b0, s});
        q = (p < 0) ? -((-p) >>> 12) : (p >>> 12);
        return q[19:0];
    endfunction

    // truncating q14 product
    function automatic logic signed [15:0] mq(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
        logic signed [31:0] p;
        logic signed [31:0] q;
        p = 32'(a) * 32'(b);
        q = (p < 0) ? -((-p) >>> 14) : (p >>> 14);
        return q[15:0];
    endfunction

    logic signed [20:0] ysum, y4, y2, yw;
    logic signed [20:0] psum;

    // angle update: yaw sum stays below eight full turns, so three
    // compare-and-subtract stages give the truncating remainder
    always_comb begin
        ysum = 21'(yaw_reg) + 21'(dyaw_reg);
        y4 = ysum;
        if (ysum >= TURN_4) y4 = ysum - TURN_4;
        else if (ysum <= -TURN_4) y4 = ysum + TURN_4;
        y2 = y4;
        if (y4 >= TURN_2) y2 = y4 - TURN_2;
        else if (y4 <= -TURN_2) y2 = y4 + TURN_2;
        yw = y2;
        if (y2 >= TURN_1) yw = y2 - TURN_1;
        else if (y2 <= -TURN_1) yw = y2 + TURN_1;
        psum = 21'(pitch_reg) + 21'(dpitch_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg <= YAW_RESET;
            pitch_reg <= '0;
        end else if (cmd.wrap) begin
            yaw_reg <= yw[17:0];
            if (psum > 21'(PITCH_LIMIT)) pitch_reg <= PITCH_LIMIT;
            else if (psum < -21'(PITCH_LIMIT)) pitch_reg <= -PITCH_LIMIT;
            else pitch_reg <= psum[15:0];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dyaw_reg <= step(s_delta_x, sens_reg);
            dpitch_reg <= step(s_delta_y, sens_reg);
        end
        if (cmd.store_yaw) begin
            sy_reg <= tsin;
            cy_reg <= tcos;
        end
        if (cmd.store_pitch) begin
            sp_reg <= tsin;
            cp_reg <= tcos;
        end
        if (cmd.mul_a) begin
            fx_reg <= mq(cy_reg, cp_reg);
            fz_reg <= mq(sy_reg, cp_reg);
        end
        if (cmd.mul_b) begin
            ux_reg <= -mq(cy_reg, sp_reg);
            uz_reg <= -mq(sy_reg, sp_reg);
        end
    end

    ecb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.trig_start),
        .angle(cmd.trig_sel ? 18'(pitch_reg) : yaw_reg),
        .done(tdone), .sin_q14(tsin), .cos_q14(tcos)
    );

    assign status.trig_done = tdone;
    assign front_x = fx_reg;
    assign front_y = sp_reg;
    assign front_z = fz_reg;
    assign right_x = -sy_reg;
    assign right_z = cy_reg;
    assign up_x = ux_reg;
    assign up_y = cp_reg;
    assign up_z = uz_reg;
    assign yaw_out = yaw_reg;
    assign pitch_out = pitch_reg;
endmodule

@@ hw/rtl/ecb_ctrl.sv @@
module ecb_ctrl import ecb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  ecb_status_t status,
    output ecb_cmd_t    cmd
);
    ecb_state_t state_reg, state_next;
    logic       pend_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.load = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.wrap = 1'b1;
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                cmd.trig_start = 1'b1;
                state_next = ST_YAW;
            end
            ST_YAW: if (status.trig_done) begin
                cmd.store_yaw = 1'b1;
                cmd.trig_start = 1'b1;
                cmd.trig_sel = 1'b1;
                state_next = ST_PITCH;
            end
            ST_PITCH: if (status.trig_done) begin
                cmd.store_pitch = 1'b1;
                state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.mul_a = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_b = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= (state_next == ST_DONE);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = pend_reg;
endmodule

@@ hw/rtl/euler_camera_basis_top.sv @@
// yaw/pitch camera basis unit
// input channel s_valid/s_ready carries one pointer-motion word (s_delta_x,
// s_delta_y); each accepted word updates the stored yaw and pitch and yields
// one result word on m_valid/m_ready: front, right and up vectors in q1.14
// plus the updated angles in 1/256 degree.
// the user must write the sensitivity register through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this. from accept to
// m_valid the controller steps through ST_STEP, ST_WRAP, ST_YAW, ST_PITCH,
// ST_MULA and ST_MULB, with one shared cordic unit that runs yaw then pitch,
// one rotation per cycle. one word is in flight at a time: a new word is
// accepted only once the result has been taken and the controller is idle.
// reset sets yaw to -90 degrees, pitch to 0 and sensitivity to 6554.
// a stalled receiver holds the result word stable; s_ready stays low until
// the cycle after the result has been taken.
module euler_camera_basis_top import ecb_pkg::*; #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_delta_x,
    input  logic signed [15:0] s_delta_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_front_x,
    output logic signed [15:0] m_front_y,
    output logic signed [15:0] m_front_z,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    output logic signed [17:0] m_yaw_out,
    output logic signed [15:0] m_pitch_out
);
    ecb_cmd_t    cmd;
    ecb_status_t status;

    ecb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .status(status), .cmd(cmd)
    );

    ecb_datapath #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_delta_x(s_delta_x), .s_delta_y(s_delta_y),
        .front_x(m_front_x), .front_y(m_front_y), .front_z(m_front_z),
        .right_x(m_right_x), .right_z(m_right_z),
        .up_x(m_up_x), .up_y(m_up_y), .up_z(m_up_z),
        .yaw_out(m_yaw_out), .pitch_out(m_pitch_out)
    );
endmodule

@@ tb/euler_camera_basis_top_test.sv @@
module euler_camera_basis_top_test;
    import ecb_pkg::*;

    localparam int TRIG_ITERS = 16;
    localparam int ATAN_DEG [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
        1, 0};

    typedef struct {
        logic signed [15:0] front_x, front_y, front_z, right_x, right_z;
        logic signed [15:0] up_x, up_y, up_z, pitch;
        logic signed [17:0] yaw;
    } basis_word_t;

    // camera orientation predictor and store of pending basis words
    class basis_scoreboard;
        longint yaw_angle, pitch_angle, sens;
        basis_word_t pending[$];
        int errors;

        function void restart();
            yaw_angle = YAW_RESET;
            pitch_angle = 0;
            sens = SENS_RESET;
            errors = 0;
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint to_q14(longint v);
            longint r;
            r = v / 65536;
            if (r > 16384) r = 16384;
            if (r < -16384) r = -16384;
            return r;
        endfunction

        // rotation-mode cordic on an angle in 1/256 degree
        function void sin_cos(longint ang, output longint s, output longint c);
            longint z, x, y, nx;
            bit neg;
            z = (ang * 256) % DEG_FULL;
            x = CORDIC_GAIN;
            y = 0;
            neg = 0;
            if (z >= DEG_HALF) z -= DEG_FULL;
            if (z < -DEG_HALF) z += DEG_FULL;
            if (z > DEG_QUARTER) begin
                z -= DEG_HALF;
                neg = 1;
            end else if (z < -DEG_QUARTER) begin
                z += DEG_HALF;
                neg = 1;
            end
            for (int i = 0; i < TRIG_ITERS && i < 24; i++) begin
                if (z >= 0) begin
                    nx = x - floor_shr(y, i);
                    y = y + floor_shr(x, i);
                    z -= ATAN_DEG[i];
                end else begin
                    nx = x + floor_shr(y, i);
                    y = y - floor_shr(x, i);
                    z += ATAN_DEG[i];
                end
                x = nx;
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            s = to_q14(y);
            c = to_q14(x);
        endfunction

        function void note_motion(logic signed [15:0] dx, logic signed [15:0] dy);
            longint yw, pt, sy, cy, sp, cp;
            basis_word_t w;
            yw = yaw_angle + (longint'(dx) * sens) / 4096;
            pt = pitch_angle + (longint'(dy) * sens) / 4096;
            yw = yw % 92160;
            if (pt > 22784) pt = 22784;
            if (pt < -22784) pt = -22784;
            yaw_angle = yw;
            pitch_angle = pt;
            sin_cos(yw, sy, cy);
            sin_cos(pt, sp, cp);
            w.front_x = 16'((cy * cp) / 16384);
            w.front_y = 16'(sp);
            w.front_z = 16'((sy * cp) / 16384);
            w.right_x = 16'(-sy);
            w.right_z = 16'(cy);
            w.up_x = 16'(-((cy * sp) / 16384));
            w.up_y = 16'(cp);
            w.up_z = 16'(-((sy * sp) / 16384));
            w.yaw = 18'(yw);
            w.pitch = 16'(pt);
            pending.push_back(w);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(basis_word_t g);
            basis_word_t e;
            if (pending.size() == 0) begin
                report("pending words", 0, 1);
                return;
            end
            e = pending.pop_front();
            if (g.front_x !== e.front_x) report("front_x", g.front_x, e.front_x);
            if (g.front_y !== e.front_y) report("front_y", g.front_y, e.front_y);
            if (g.front_z !== e.front_z) report("front_z", g.front_z, e.front_z);
            if (g.right_x !== e.right_x) report("right_x", g.right_x, e.right_x);
            if (g.right_z !== e.right_z) report("right_z", g.right_z, e.right_z);
            if (g.up_x !== e.up_x) report("up_x", g.up_x, e.up_x);
            if (g.up_y !== e.up_y) report("up_y", g.up_y, e.up_y);
            if (g.up_z !== e.up_z) report("up_z", g.up_z, e.up_z);
            if (g.yaw !== e.yaw) report("yaw", g.yaw, e.yaw);
            if (g.pitch !== e.pitch) report("pitch", g.pitch, e.pitch);
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_delta_x = '0, s_delta_y = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_front_x, m_front_y, m_front_z, m_right_x, m_right_z;
    logic signed [15:0] m_up_x, m_up_y, m_up_z, m_pitch_out;
    logic signed [17:0] m_yaw_out;

    int send_idle_pct = 28;
    int recv_idle_pct = 48;
    basis_scoreboard sb;

    always #2 aclk = ~aclk;

    euler_camera_basis_top #(.TRIG_ITERATIONS(TRIG_ITERS)) dut (.*);

    // result side: random stalls, check accepted words
    always @(posedge aclk) begin
        basis_word_t g;
        if (aresetn && m_valid && m_ready) begin
            g.front_x = m_front_x; g.front_y = m_front_y; g.front_z = m_front_z;
            g.right_x = m_right_x; g.right_z = m_right_z;
            g.up_x = m_up_x; g.up_y = m_up_y; g.up_z = m_up_z;
            g.yaw = m_yaw_out; g.pitch = m_pitch_out;
            sb.check_word(g);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one motion word, with optional idle cycles first
    task automatic send_motion(logic signed [15:0] dx, logic signed [15:0] dy);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_delta_x <= dx;
        s_delta_y <= dy;
        do @(posedge aclk); while (!s_ready);
        sb.note_motion(dx, dy);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_sens(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.sens = v;
    endtask

    function automatic logic signed [15:0] rand_delta();
        case ($urandom_range(3))
            0: return 16'($urandom_range(400) - 200);
            1: return 16'($urandom_range(8000) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        sb = new();
        sb.restart();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, yaw wrap both ways, pitch clamp both ways
        send_motion(16'sd0, 16'sd0);
        send_motion(16'sh7fff, 16'sh7fff);
        send_motion(16'sh7fff, 16'sh7fff);
        send_motion(-16'sh8000, -16'sh8000);
        send_motion(-16'sh8000, -16'sh8000);
        send_motion(-16'sh8000, 16'sd0);
        send_motion(16'sh5555, 16'shaaaa);
        send_motion(-16'sd1, 16'sd1);
        write_sens(16'hffff);
        for (int i = 0; i < 6; i++) send_motion(16'sh7fff, 16'sh7fff);
        for (int i = 0; i < 6; i++) send_motion(-16'sh8000, -16'sh8000);
        write_sens(16'd655);
        send_motion(16'sh7fff, -16'sh8000);
        send_motion(16'sd1, -16'sd1);
        write_sens(16'd32768);
        send_motion(16'sh7fff, 16'sh1000);

        // random phases over several sensitivities
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 48;
                recv_idle_pct = 28;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int j = 0; j < 4; j++) begin
                write_sens(j == 0 ? 16'd655 : j == 1 ? 16'd32768 :
                           j == 2 ? 16'($urandom) : 16'($urandom_range(32768, 655)));
                for (int k = 0; k < 50; k++) begin
                    send_motion(rand_delta(), rand_delta());
                    if (k == 25) drain();
                end
            end
        end

        drain();
        if (sb.errors == 0)
            $display("euler_camera_basis_top_test passed");
        else
            $display("euler_camera_basis_top_test failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("euler_camera_basis_top_test failed");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/ecb_pkg.sv
hw/rtl/ecb_cordic.sv
hw/rtl/ecb_datapath.sv
hw/rtl/ecb_ctrl.sv
hw/rtl/euler_camera_basis_top.sv
tb/euler_camera_basis_top_test.sv
